### rtl/tlc_pkg.sv
`timescale 1ns / 1ps
// shared constants, row types and tag-store helper functions for the cache lookup
// no dependencies
package tlc_pkg;

  localparam int ADDR_BITS      = 32;
  localparam int L1_SETS_LOG2   = 6;
  localparam int L1_WAYS_LOG2   = 2;
  localparam int L2_SETS_LOG2   = 8;
  localparam int L2_WAYS_LOG2   = 3;
  localparam int L1_WAYS        = 1 << L1_WAYS_LOG2;
  localparam int L2_WAYS        = 1 << L2_WAYS_LOG2;
  localparam int L1_SETS        = 1 << L1_SETS_LOG2;
  localparam int L2_SETS        = 1 << L2_SETS_LOG2;
  localparam int MAX_BLOCK_LOG2 = 12;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_L1_SETS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_L1_WAYS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_L2_SETS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_L2_WAYS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WR_ALLOC   = 3'd5;

  localparam logic [3:0] RST_BLOCK_LOG2 = 4'd5;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [1:0] HIT_L1   = 2'd0;
  localparam logic [1:0] HIT_L2   = 2'd1;
  localparam logic [1:0] HIT_NONE = 2'd2;

  typedef logic [ADDR_BITS-1:0]    blk_t;
  typedef logic [L1_SETS_LOG2-1:0] l1_set_t;
  typedef logic [L2_SETS_LOG2-1:0] l2_set_t;
  typedef logic [L1_WAYS_LOG2-1:0] l1_way_t;
  typedef logic [L2_WAYS_LOG2-1:0] l2_way_t;
  typedef logic [L1_WAYS_LOG2:0]   l1_cnt_t;
  typedef logic [L2_WAYS_LOG2:0]   l2_cnt_t;

  typedef struct packed {
    logic    v;
    logic    d;
    l1_way_t rank;
    blk_t    tag;
  } l1_ent_t;

  typedef struct packed {
    logic    v;
    logic    d;
    l2_way_t rank;
    blk_t    tag;
  } l2_ent_t;

  typedef l1_ent_t [L1_WAYS-1:0] l1_row_t;
  typedef l2_ent_t [L2_WAYS-1:0] l2_row_t;

  typedef struct packed {
    logic    hit;
    l1_way_t way;
  } l1_find_t;

  typedef struct packed {
    logic    hit;
    l2_way_t way;
  } l2_find_t;

  // controller to datapath
  typedef struct packed {
    logic clr;
    logic accept;
    logic look;
    logic binv;
    logic fill;
    logic wb;
    logic load;
  } tlc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic l1_hit;
    logic need_fill;
    logic binv_pend;
    logic wb_pend;
  } tlc_sts_t;

  typedef struct packed {
    logic [1:0] hit_level;
    logic       l1_filled;
    logic       l2_filled;
    logic       l1_dirty_evicted;
    logic       back_invalidated;
  } tlc_res_t;

  function automatic l1_find_t l1_find(l1_row_t row, l1_cnt_t n, blk_t blk);
    l1_find_t f;
    f = '0;
    // lowest matching way wins
    for (int w = L1_WAYS - 1; w >= 0; w--) begin
      if (w < int'(n) && row[w].v && row[w].tag == blk) begin
        f.hit = 1'b1;
        f.way = w[L1_WAYS_LOG2-1:0];
      end
    end
    return f;
  endfunction

  function automatic l2_find_t l2_find(l2_row_t row, l2_cnt_t n, blk_t blk);
    l2_find_t f;
    f = '0;
    for (int w = L2_WAYS - 1; w >= 0; w--) begin
      if (w < int'(n) && row[w].v && row[w].tag == blk) begin
        f.hit = 1'b1;
        f.way = w[L2_WAYS_LOG2-1:0];
      end
    end
    return f;
  endfunction

  function automatic l1_way_t l1_victim(l1_row_t row, l1_cnt_t n);
    l1_way_t best;
    l1_way_t inv;
    logic    has_inv;
    best    = '0;
    inv     = '0;
    has_inv = 1'b0;
    for (int w = L1_WAYS - 1; w >= 0; w--) begin
      if (w < int'(n) && !row[w].v) begin
        has_inv = 1'b1;
        inv     = w[L1_WAYS_LOG2-1:0];
      end
    end
    for (int w = 1; w < L1_WAYS; w++) begin
      if (w < int'(n) && row[w].rank > row[best].rank) best = w[L1_WAYS_LOG2-1:0];
    end
    return has_inv ? inv : best;
  endfunction

  function automatic l2_way_t l2_victim(l2_row_t row, l2_cnt_t n);
    l2_way_t best;
    l2_way_t inv;
    logic    has_inv;
    best    = '0;
    inv     = '0;
    has_inv = 1'b0;
    for (int w = L2_WAYS - 1; w >= 0; w--) begin
      if (w < int'(n) && !row[w].v) begin
        has_inv = 1'b1;
        inv     = w[L2_WAYS_LOG2-1:0];
      end
    end
    for (int w = 1; w < L2_WAYS; w++) begin
      if (w < int'(n) && row[w].rank > row[best].rank) best = w[L2_WAYS_LOG2-1:0];
    end
    return has_inv ? inv : best;
  endfunction

  // make a way most recently used, aging the active ways that were younger
  function automatic l1_row_t l1_touch(l1_row_t row, l1_way_t way, l1_cnt_t n);
    l1_way_t r;
    l1_row_t o;
    r = row[way].rank;
    o = row;
    for (int w = 0; w < L1_WAYS; w++) begin
      if (w < int'(n) && row[w].rank < r) o[w].rank = row[w].rank + 1'b1;
    end
    o[way].rank = '0;
    return o;
  endfunction

  function automatic l2_row_t l2_touch(l2_row_t row, l2_way_t way, l2_cnt_t n);
    l2_way_t r;
    l2_row_t o;
    r = row[way].rank;
    o = row;
    for (int w = 0; w < L2_WAYS; w++) begin
      if (w < int'(n) && row[w].rank < r) o[w].rank = row[w].rank + 1'b1;
    end
    o[way].rank = '0;
    return o;
  endfunction

  function automatic l1_row_t l1_clear_row();
    l1_row_t o;
    o = '0;
    for (int w = 0; w < L1_WAYS; w++) o[w].rank = w[L1_WAYS_LOG2-1:0];
    return o;
  endfunction

  function automatic l2_row_t l2_clear_row();
    l2_row_t o;
    o = '0;
    for (int w = 0; w < L2_WAYS; w++) o[w].rank = w[L2_WAYS_LOG2-1:0];
    return o;
  endfunction

endpackage

### rtl/tlc_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for access beats and result beats
// depends on tlc_pkg
interface tlc_in_if import tlc_pkg::*; ;
  logic                 valid;
  logic                 ready;
  logic                 opcode;
  logic [ADDR_BITS-1:0] address;

  modport source (output valid, output opcode, output address, input ready);
  modport sink   (input valid, input opcode, input address, output ready);
endinterface

interface tlc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] hit_level;
  logic       l1_filled;
  logic       l2_filled;
  logic       l1_dirty_evicted;
  logic       back_invalidated;

  modport source (output valid, output hit_level, output l1_filled, output l2_filled,
                  output l1_dirty_evicted, output back_invalidated, input ready);
  modport sink   (input valid, input hit_level, input l1_filled, input l2_filled,
                  input l1_dirty_evicted, input back_invalidated, output ready);
endinterface

### rtl/tlc_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies
module tlc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/tlc_ctrl.sv
`timescale 1ns / 1ps
// sequencer for the lookup: clear sweep, lookup, back-invalidate, fill, writeback
// depends on tlc_pkg
module tlc_ctrl import tlc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output tlc_cmd_t cmd,
  input  tlc_sts_t sts
);

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_LOOK,
    ST_BINV,
    ST_FILL,
    ST_WB,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;
  logic   load;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign load      = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    cmd        = '0;
    cmd.clr    = (state_r == ST_CLR);
    cmd.accept = (state_r == ST_IDLE) && in_valid;
    cmd.look   = (state_r == ST_LOOK);
    cmd.binv   = (state_r == ST_BINV);
    cmd.fill   = (state_r == ST_FILL);
    cmd.wb     = (state_r == ST_WB);
    cmd.load   = load;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR:  if (sts.clr_last) state_nxt = ST_IDLE;
      ST_IDLE: if (in_valid) state_nxt = ST_LOOK;
      ST_LOOK: begin
        if (sts.l1_hit) state_nxt = ST_DONE;
        else if (sts.binv_pend) state_nxt = ST_BINV;
        else if (sts.need_fill) state_nxt = ST_FILL;
        else state_nxt = ST_DONE;
      end
      ST_BINV: state_nxt = ST_FILL;
      ST_FILL: state_nxt = sts.wb_pend ? ST_WB : ST_DONE;
      ST_WB:   state_nxt = ST_DONE;
      ST_DONE: if (load) state_nxt = ST_IDLE;
      default: state_nxt = ST_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= load || (out_valid_r && !out_ready);
    end
  end

endmodule

### rtl/tlc_dp.sv
`timescale 1ns / 1ps
// tag-store datapath: config registers, l1/l2 set rows in ram, lookup and update logic
// depends on tlc_pkg and tlc_ram
module tlc_dp import tlc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tlc_cmd_t              cmd,
  output tlc_sts_t              sts,
  input  logic                  in_opcode,
  input  logic [ADDR_BITS-1:0]  in_address,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output tlc_res_t              res
);

  // config, stored already saturated
  logic [3:0]              bsh_r;
  logic [2:0]              l1s_r;
  logic [L1_WAYS_LOG2-1:0] l1w_r;
  logic [3:0]              l2s_r;
  logic [L2_WAYS_LOG2-1:0] l2w_r;
  logic                    wa_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bsh_r <= RST_BLOCK_LOG2;
      l1s_r <= 3'(L1_SETS_LOG2);
      l1w_r <= L1_WAYS_LOG2'(L1_WAYS_LOG2);
      l2s_r <= 4'(L2_SETS_LOG2);
      l2w_r <= L2_WAYS_LOG2'(L2_WAYS_LOG2);
      wa_r  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BLOCK_SIZE:
          bsh_r <= (cfg_wdata > 4'(MAX_BLOCK_LOG2)) ? 4'(MAX_BLOCK_LOG2) : cfg_wdata;
        CFG_L1_SETS:
          l1s_r <= (cfg_wdata[2:0] > 3'(L1_SETS_LOG2)) ? 3'(L1_SETS_LOG2) : cfg_wdata[2:0];
        CFG_L1_WAYS:
          l1w_r <= (cfg_wdata[1:0] > 2'(L1_WAYS_LOG2)) ? L1_WAYS_LOG2'(L1_WAYS_LOG2)
                                                       : L1_WAYS_LOG2'(cfg_wdata[1:0]);
        CFG_L2_SETS:
          l2s_r <= (cfg_wdata > 4'(L2_SETS_LOG2)) ? 4'(L2_SETS_LOG2) : cfg_wdata;
        CFG_L2_WAYS:
          l2w_r <= (cfg_wdata[1:0] > 2'(L2_WAYS_LOG2)) ? L2_WAYS_LOG2'(L2_WAYS_LOG2)
                                                       : L2_WAYS_LOG2'(cfg_wdata[1:0]);
        CFG_WR_ALLOC: wa_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  l1_set_t m1;
  l2_set_t m2;
  l1_cnt_t n1;
  l2_cnt_t n2;
  blk_t    blk_in;

  assign m1     = ~({L1_SETS_LOG2{1'b1}} << l1s_r);
  assign m2     = ~({L2_SETS_LOG2{1'b1}} << l2s_r);
  assign n1     = l1_cnt_t'(1) << l1w_r;
  assign n2     = l2_cnt_t'(1) << l2w_r;
  assign blk_in = in_address >> bsh_r;

  // per-access registers
  logic    wr_r;
  blk_t    blk_r;
  l1_set_t s1_r;
  l2_set_t s2_r;
  blk_t    vtag_r;
  l1_set_t vb1_r;
  l2_set_t vb2_r;
  l1_row_t l1row_r;
  logic [1:0] hit_r;
  logic    f1_r, f2_r, dev_r, binv_r;
  tlc_res_t res_r;
  logic [L2_SETS_LOG2-1:0] cnt_r;

  // memories
  l1_row_t l1q, l1_wdata;
  l2_row_t l2q, l2_wdata;
  logic    l1_we, l2_we;
  l1_set_t l1_waddr, l1_raddr;
  l2_set_t l2_waddr, l2_raddr;

  tlc_ram #(.WIDTH($bits(l1_row_t)), .DEPTH(L1_SETS)) u_l1_ram (
    .clk  (clk),
    .we   (l1_we),
    .waddr(l1_waddr),
    .wdata(l1_wdata),
    .raddr(l1_raddr),
    .rdata(l1q)
  );

  tlc_ram #(.WIDTH($bits(l2_row_t)), .DEPTH(L2_SETS)) u_l2_ram (
    .clk  (clk),
    .we   (l2_we),
    .waddr(l2_waddr),
    .wdata(l2_wdata),
    .raddr(l2_raddr),
    .rdata(l2q)
  );

  // lookup step
  l1_find_t f1q;
  l2_find_t f2q;
  l2_way_t  v2;
  logic     need_fill;
  logic     l2_alloc;
  l1_row_t  l1_hitrow;
  l2_row_t  l2_look;
  blk_t     l2_vtag;
  // back-invalidate step
  l1_find_t fb;
  l1_row_t  l1_bi;
  // fill step
  l1_way_t  v1;
  blk_t     l1_vtag;
  l1_row_t  l1_fill;
  // writeback step
  l2_find_t fw;
  l2_row_t  l2_wb;

  always_comb begin
    f1q       = l1_find(l1q, n1, blk_r);
    f2q       = l2_find(l2q, n2, blk_r);
    v2        = l2_victim(l2q, n2);
    need_fill = (wr_r != OP_WRITE) || wa_r;
    l2_alloc  = !f2q.hit && need_fill;
    l2_vtag   = l2q[v2].tag;

    l1_hitrow = l1_touch(l1q, f1q.way, n1);
    if (wr_r == OP_WRITE) l1_hitrow[f1q.way].d = 1'b1;

    l2_look = l2q;
    if (f2q.hit) begin
      l2_look = l2_touch(l2q, f2q.way, n2);
      if (wr_r == OP_WRITE && !wa_r) l2_look[f2q.way].d = 1'b1;
    end else begin
      l2_look[v2].v   = 1'b1;
      l2_look[v2].d   = 1'b0;
      l2_look[v2].tag = blk_r;
      l2_look         = l2_touch(l2_look, v2, n2);
    end

    fb    = l1_find(l1q, n1, vtag_r);
    l1_bi = l1q;
    l1_bi[fb.way].v = 1'b0;
    l1_bi[fb.way].d = 1'b0;

    v1      = l1_victim(l1row_r, n1);
    l1_vtag = l1row_r[v1].tag;
    l1_fill = l1row_r;
    l1_fill[v1].v   = 1'b1;
    l1_fill[v1].d   = (wr_r == OP_WRITE);
    l1_fill[v1].tag = blk_r;
    l1_fill         = l1_touch(l1_fill, v1, n1);

    fw    = l2_find(l2q, n2, vtag_r);
    l2_wb = l2_touch(l2q, fw.way, n2);
    l2_wb[fw.way].d = 1'b1;
  end

  always_comb begin
    sts.clr_last  = (cnt_r == {L2_SETS_LOG2{1'b1}});
    sts.l1_hit    = f1q.hit;
    sts.need_fill = need_fill;
    sts.binv_pend = !f1q.hit && l2_alloc && l2q[v2].v;
    sts.wb_pend   = l1row_r[v1].v && l1row_r[v1].d;
  end

  // ram port steering
  always_comb begin
    l1_raddr = cmd.look ? (l2_vtag[L1_SETS_LOG2-1:0] & m1) : (blk_in[L1_SETS_LOG2-1:0] & m1);
    l2_raddr = cmd.fill ? (l1_vtag[L2_SETS_LOG2-1:0] & m2) : (blk_in[L2_SETS_LOG2-1:0] & m2);

    l1_we    = 1'b0;
    l1_waddr = s1_r;
    l1_wdata = l1_fill;
    if (cmd.clr) begin
      l1_we    = ((cnt_r >> L1_SETS_LOG2) == '0);
      l1_waddr = cnt_r[L1_SETS_LOG2-1:0];
      l1_wdata = l1_clear_row();
    end else if (cmd.look) begin
      l1_we    = f1q.hit;
      l1_wdata = l1_hitrow;
    end else if (cmd.binv) begin
      l1_we    = fb.hit;
      l1_waddr = vb1_r;
      l1_wdata = l1_bi;
    end else if (cmd.fill) begin
      l1_we    = 1'b1;
    end

    l2_we    = 1'b0;
    l2_waddr = s2_r;
    l2_wdata = l2_look;
    if (cmd.clr) begin
      l2_we    = 1'b1;
      l2_waddr = cnt_r;
      l2_wdata = l2_clear_row();
    end else if (cmd.look) begin
      l2_we    = !f1q.hit && (f2q.hit || need_fill);
    end else if (cmd.wb) begin
      l2_we    = fw.hit;
      l2_waddr = vb2_r;
      l2_wdata = l2_wb;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.clr) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      wr_r   <= in_opcode;
      blk_r  <= blk_in;
      s1_r   <= blk_in[L1_SETS_LOG2-1:0] & m1;
      s2_r   <= blk_in[L2_SETS_LOG2-1:0] & m2;
      hit_r  <= HIT_L1;
      f1_r   <= 1'b0;
      f2_r   <= 1'b0;
      dev_r  <= 1'b0;
      binv_r <= 1'b0;
    end
    if (cmd.look) begin
      l1row_r <= l1q;
      vtag_r  <= l2_vtag;
      vb1_r   <= l2_vtag[L1_SETS_LOG2-1:0] & m1;
      if (!f1q.hit) begin
        hit_r <= f2q.hit ? HIT_L2 : HIT_NONE;
        f2_r  <= l2_alloc;
      end
    end
    if (cmd.binv) begin
      binv_r <= fb.hit;
      // victim copy may sit in the set being filled
      if (fb.hit && vb1_r == s1_r) l1row_r <= l1_bi;
    end
    if (cmd.fill) begin
      f1_r   <= 1'b1;
      vtag_r <= l1_vtag;
      vb2_r  <= l1_vtag[L2_SETS_LOG2-1:0] & m2;
    end
    if (cmd.wb) begin
      dev_r <= fw.hit;
    end
    if (cmd.load) begin
      res_r.hit_level        <= hit_r;
      res_r.l1_filled        <= f1_r;
      res_r.l2_filled        <= f2_r;
      res_r.l1_dirty_evicted <= dev_r;
      res_r.back_invalidated <= binv_r;
    end
  end

  assign res = res_r;

endmodule

### rtl/two_level_inclusive_cache_lookup.sv
`timescale 1ns / 1ps
// Two-level inclusive set-associative tag lookup with true LRU and write-back dirty bits.
// Access beats arrive on in_ch (opcode, byte address); one result beat per access
// leaves on out_ch (hit level plus fill, dirty-evict and back-invalidate flags).
// Geometry and write-allocate are set through the cfg_ write port while idle; the user
// must keep to this, as the block does not enforce it. Changes apply from the next
// access and do not flush stored lines.
// Steps: an access is accepted in the idle state; then come a lookup on both set rows
// and, as needed, a back-invalidate of the L1 copy of an L2 victim, an L1 fill and a
// mark of the L2 copy of a dirty L1 victim, and last the load of the result register.
// The single read port of each set ram sets these steps. One access is in flight
// at a time.
// Reset: after rst_n the block sweeps both set rams, one row per cycle, through all 256
// L2 rows (in_ch.ready low, config writes still taken), clearing valid and dirty bits.
// Stall: the result register holds a beat until out_ch.ready; the next access can
// be accepted while it waits, but its own result waits for the register to drain.
// depends on tlc_pkg, tlc_if, tlc_ctrl, tlc_dp
module two_level_inclusive_cache_lookup import tlc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  tlc_in_if.sink                in_ch,
  tlc_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  tlc_cmd_t cmd;
  tlc_sts_t sts;
  tlc_res_t res;

  tlc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  tlc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_opcode (in_ch.opcode),
    .in_address(in_ch.address),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .res       (res)
  );

  assign out_ch.hit_level        = res.hit_level;
  assign out_ch.l1_filled        = res.l1_filled;
  assign out_ch.l2_filled        = res.l2_filled;
  assign out_ch.l1_dirty_evicted = res.l1_dirty_evicted;
  assign out_ch.back_invalidated = res.back_invalidated;

`ifndef SYNTH
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("second access taken while one is in flight");

  a_hit_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.hit_level != 2'd3)
    else $error("unused hit level code");

  a_l1_hit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.hit_level == HIT_L1 |->
      !out_ch.l1_filled && !out_ch.l2_filled && !out_ch.back_invalidated)
    else $error("events reported on an L1 hit");

  a_binv_needs_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.back_invalidated |->
      out_ch.l2_filled && out_ch.hit_level == HIT_NONE)
    else $error("back-invalidate without an L2 fill");
`endif

endmodule
